FILE: rtl/core/cfe_pkg.sv
// Shared constants, datapath command codes and interface structs for the
// two-dimensional Chebyshev field evaluator. No dependencies.
package cfe_pkg;

	// Series size per axis and the coefficient store it implies
	localparam int MAX_TERMS   = 8;
	localparam int TERM_W      = $clog2(MAX_TERMS);
	localparam int STORE_DEPTH = MAX_TERMS * MAX_TERMS;
	localparam int ADDR_W      = 2 * TERM_W;

	// Field and register widths
	localparam int COEFF_W   = 32;
	localparam int POS_W     = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int VAL_W     = 48;

	// Arithmetic widths and fixed-point positions
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 32;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 80;
	localparam int SPLIT     = 24;
	localparam int SUM_W     = 53;
	localparam int MAP_W     = 66;
	localparam int MAP_FRAC  = 12;
	localparam int FRAC_STEP = 29;
	localparam int FRAC_LAST = 30;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [COEFF_W-1:0] COORD_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
	localparam logic signed [COEFF_W-1:0] COORD_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

	// Input operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd5;

	// Datapath operation codes
	localparam logic [2:0] DP_NOP      = 3'd0;
	localparam logic [2:0] DP_MAPX_MUL = 3'd1;
	localparam logic [2:0] DP_MAPX_FIN = 3'd2;
	localparam logic [2:0] DP_MAPY_MUL = 3'd3;
	localparam logic [2:0] DP_MAPY_FIN = 3'd4;
	localparam logic [2:0] DP_LO       = 3'd5;
	localparam logic [2:0] DP_HI       = 3'd6;
	localparam logic [2:0] DP_ADD      = 3'd7;

	typedef struct packed {
		logic [2:0]        op;
		logic              outer;
		logic              last;
		logic              load_pos;
		logic              coeff_we;
		logic              coeff_re;
		logic [ADDR_W-1:0] coeff_raddr;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] x_scale;
		logic [CFG_W-1:0] x_offset;
		logic [CFG_W-1:0] y_scale;
		logic [CFG_W-1:0] y_offset;
	} map_cfg_t;

endpackage

FILE: rtl/core/chebyshev_2d_field_evaluator_top.sv
// Top level of the two-dimensional Chebyshev field evaluator: configuration
// registers plus the sequencer and datapath. Depends on cfe_pkg, cfe_ctrl,
// cfe_datapath and cfe_ram.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | operation, coeff_index, coeff_value,
//           |                      | pos_x, pos_y
//   out     | out_valid/out_ready  | field_value, saturated
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Coefficient writes are taken in the idle state. In an evaluation each recurrence
// step makes two passes through the one shared 33x32 multiplier and one add.
// Evaluations run one at a time; the next beat is taken as soon as the result
// sits in the output register, and a stalled output only holds the final cycle.
// Reset clears control and configuration; the coefficient store is not cleared.
module chebyshev_2d_field_evaluator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 operation,
	input  logic [cfe_pkg::ADDR_W-1:0]           coeff_index,
	input  logic signed [cfe_pkg::COEFF_W-1:0]   coeff_value,
	input  logic signed [cfe_pkg::POS_W-1:0]     pos_x,
	input  logic signed [cfe_pkg::POS_W-1:0]     pos_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [cfe_pkg::VAL_W-1:0]     field_value,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cfe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cfe_pkg::CFG_W-1:0]            cfg_data
);
	import cfe_pkg::*;

	logic [TERM_W-1:0] order_x_q;
	logic [TERM_W-1:0] order_y_q;
	map_cfg_t          map_cfg_q;
	dp_cmd_t           cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_x_q <= '0;
			order_y_q <= '0;
			map_cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORDER_X:  order_x_q          <= cfg_data[TERM_W-1:0];
				REG_ORDER_Y:  order_y_q          <= cfg_data[TERM_W-1:0];
				REG_X_SCALE:  map_cfg_q.x_scale  <= cfg_data;
				REG_X_OFFSET: map_cfg_q.x_offset <= cfg_data;
				REG_Y_SCALE:  map_cfg_q.y_scale  <= cfg_data;
				REG_Y_OFFSET: map_cfg_q.y_offset <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.order_x  (order_x_q),
		.order_y  (order_y_q),
		.cmd      (cmd)
	);

	cfe_datapath u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.map_cfg    (map_cfg_q),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.field_value(field_value),
		.saturated  (saturated)
	);

endmodule

FILE: rtl/core/cfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependencies.
module cfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/cfe_ctrl.sv
// Sequencer for the Chebyshev field evaluator: accepts beats, walks the row
// and outer recurrences and issues datapath commands. Depends on cfe_pkg.
module cfe_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  logic [cfe_pkg::TERM_W-1:0]   order_x,
	input  logic [cfe_pkg::TERM_W-1:0]   order_y,
	output cfe_pkg::dp_cmd_t             cmd
);
	import cfe_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MAPX_MUL = 4'd1;
	localparam logic [3:0] S_MAPX_FIN = 4'd2;
	localparam logic [3:0] S_MAPY_MUL = 4'd3;
	localparam logic [3:0] S_MAPY_FIN = 4'd4;
	localparam logic [3:0] S_LO       = 4'd5;
	localparam logic [3:0] S_HI       = 4'd6;
	localparam logic [3:0] S_ADD      = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]        state_q;
	logic [3:0]        state_d;
	logic [TERM_W-1:0] i_q;
	logic [TERM_W-1:0] j_q;
	logic              outer_q;
	logic              out_valid_q;
	logic              last;

	assign last      = outer_q ? (j_q == '0) : (i_q == '0);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.outer       = outer_q;
		cmd.last        = last;
		cmd.coeff_raddr = {j_q, i_q};
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_WRITE) begin
						cmd.coeff_we = 1'b1;
					end else begin
						cmd.load_pos = 1'b1;
						state_d      = S_MAPX_MUL;
					end
				end
			end
			S_MAPX_MUL: begin
				cmd.op  = DP_MAPX_MUL;
				state_d = S_MAPX_FIN;
			end
			S_MAPX_FIN: begin
				cmd.op  = DP_MAPX_FIN;
				state_d = S_MAPY_MUL;
			end
			S_MAPY_MUL: begin
				cmd.op  = DP_MAPY_MUL;
				state_d = S_MAPY_FIN;
			end
			S_MAPY_FIN: begin
				cmd.op  = DP_MAPY_FIN;
				state_d = S_LO;
			end
			S_LO: begin
				cmd.op       = DP_LO;
				cmd.coeff_re = !outer_q;
				state_d      = S_HI;
			end
			S_HI: begin
				cmd.op  = DP_HI;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.op  = DP_ADD;
				state_d = (outer_q && last) ? S_DONE : S_LO;
			end
			S_DONE: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			outer_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_MAPY_FIN: begin
					i_q     <= order_x;
					j_q     <= order_y;
					outer_q <= 1'b0;
				end
				S_ADD: begin
					if (outer_q) begin
						// row done and folded in: advance to the next lower row
						if (!last) begin
							j_q     <= j_q - 1'b1;
							i_q     <= order_x;
							outer_q <= 1'b0;
						end
					end else if (last) begin
						outer_q <= 1'b1;
					end else begin
						i_q <= i_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/cfe_datapath.sv
// Datapath of the Chebyshev field evaluator: coordinate mapping, one shared
// split multiplier, recurrence registers and the output register.
// Depends on cfe_pkg and cfe_ram.
module cfe_datapath (
	input  logic                                 clk,
	input  cfe_pkg::dp_cmd_t                     cmd,
	input  cfe_pkg::map_cfg_t                    map_cfg,
	input  logic [cfe_pkg::ADDR_W-1:0]           coeff_index,
	input  logic signed [cfe_pkg::COEFF_W-1:0]   coeff_value,
	input  logic signed [cfe_pkg::POS_W-1:0]     pos_x,
	input  logic signed [cfe_pkg::POS_W-1:0]     pos_y,
	output logic signed [cfe_pkg::VAL_W-1:0]     field_value,
	output logic                                 saturated
);
	import cfe_pkg::*;

	localparam logic signed [ACC_W-1:0] RND_STEP = ACC_W'(1) <<< (FRAC_STEP - 1);
	localparam logic signed [ACC_W-1:0] RND_LAST = ACC_W'(1) <<< (FRAC_LAST - 1);
	localparam logic signed [MAP_W-1:0] MAP_RND  = MAP_W'(1) <<< (MAP_FRAC - 1);

	logic signed [POS_W-1:0]   pos_x_q;
	logic signed [POS_W-1:0]   pos_y_q;
	logic signed [COEFF_W-1:0] u_q;
	logic signed [COEFF_W-1:0] v_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   prod_q;
	logic signed [VAL_W-1:0]   ib1_q;
	logic signed [VAL_W-1:0]   ib2_q;
	logic signed [VAL_W-1:0]   ob1_q;
	logic signed [VAL_W-1:0]   ob2_q;
	logic signed [VAL_W-1:0]   row_q;
	logic                      flag_q;
	logic signed [VAL_W-1:0]   field_value_q;
	logic                      saturated_q;

	logic [COEFF_W-1:0]        ram_rdata;
	logic [VAL_W-1:0]          b1_sel;
	logic signed [VAL_W-1:0]   b2_sel;
	logic signed [VAL_W-1:0]   g_sel;
	logic signed [COEFF_W-1:0] coord;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [ACC_W-1:0]   rnd;
	logic signed [ACC_W-1:0]   shifted;
	logic signed [SUM_W-1:0]   sum;
	logic                      step_ovf;
	logic signed [VAL_W-1:0]   step_res;
	logic [CFG_W-1:0]          map_off;
	logic signed [MAP_W-1:0]   map_sum;
	logic                      map_ovf;
	logic signed [COEFF_W-1:0] map_res;

	cfe_ram #(
		.WIDTH(COEFF_W),
		.DEPTH(STORE_DEPTH)
	) u_coeff_ram (
		.clk  (clk),
		.we   (cmd.coeff_we),
		.waddr(coeff_index),
		.wdata(coeff_value),
		.re   (cmd.coeff_re),
		.raddr(cmd.coeff_raddr),
		.rdata(ram_rdata)
	);

	assign b1_sel = cmd.outer ? ob1_q : ib1_q;
	assign b2_sel = cmd.outer ? ob2_q : ib2_q;
	assign coord  = cmd.outer ? v_q : u_q;
	assign g_sel  = cmd.outer ? row_q : VAL_W'($signed(ram_rdata));

	// Shared multiplier: position times scale, or one half of b times coordinate
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_MAPX_MUL: begin
				mul_a = MUL_A_W'(pos_x_q);
				mul_b = $signed(map_cfg.x_scale);
			end
			DP_MAPY_MUL: begin
				mul_a = MUL_A_W'(pos_y_q);
				mul_b = $signed(map_cfg.y_scale);
			end
			DP_LO: begin
				mul_a = $signed({{(MUL_A_W-SPLIT){1'b0}}, b1_sel[SPLIT-1:0]});
				mul_b = coord;
			end
			DP_HI: begin
				mul_a = MUL_A_W'($signed(b1_sel[VAL_W-1:SPLIT]));
				mul_b = coord;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign rnd   = cmd.last ? RND_LAST : RND_STEP;

	// Recurrence step: g + round(b1 * coord) - b2, saturated to the value range
	assign shifted  = cmd.last ? (prod_q >>> FRAC_LAST) : (prod_q >>> FRAC_STEP);
	assign sum      = SUM_W'(g_sel) + SUM_W'(shifted) - SUM_W'(b2_sel);
	assign step_ovf = !((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]));
	assign step_res = step_ovf ? (sum[SUM_W-1] ? VAL_MIN : VAL_MAX) : sum[VAL_W-1:0];

	// Coordinate mapping: round the Q20.12 * Q2.30 product, add offset, saturate
	assign map_off = (cmd.op == DP_MAPX_FIN) ? map_cfg.x_offset : map_cfg.y_offset;
	assign map_sum = ((MAP_W'($signed(prod_q[2*POS_W-1:0])) + MAP_RND) >>> MAP_FRAC)
		+ MAP_W'($signed(map_off));
	assign map_ovf = !((&map_sum[MAP_W-1:COEFF_W-1]) || !(|map_sum[MAP_W-1:COEFF_W-1]));
	assign map_res = map_ovf ? (map_sum[MAP_W-1] ? COORD_MIN : COORD_MAX)
		: map_sum[COEFF_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_pos) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
		end
		case (cmd.op)
			DP_MAPX_MUL, DP_MAPY_MUL: begin
				prod_q <= ACC_W'(mul_p);
			end
			DP_MAPX_FIN: begin
				u_q    <= map_res;
				flag_q <= map_ovf;
			end
			DP_MAPY_FIN: begin
				v_q    <= map_res;
				flag_q <= flag_q | map_ovf;
				ib1_q  <= '0;
				ib2_q  <= '0;
				ob1_q  <= '0;
				ob2_q  <= '0;
			end
			DP_LO: begin
				acc_q <= ACC_W'(mul_p) + rnd;
			end
			DP_HI: begin
				prod_q <= acc_q + (ACC_W'(mul_p) <<< SPLIT);
			end
			DP_ADD: begin
				flag_q <= flag_q | step_ovf;
				if (cmd.outer) begin
					ob2_q <= ob1_q;
					ob1_q <= step_res;
				end else if (cmd.last) begin
					// row finished: hand it to the outer recurrence, restart the row state
					row_q <= step_res;
					ib1_q <= '0;
					ib2_q <= '0;
				end else begin
					ib2_q <= ib1_q;
					ib1_q <= step_res;
				end
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			field_value_q <= ob1_q;
			saturated_q   <= flag_q;
		end
	end

	assign field_value = field_value_q;
	assign saturated   = saturated_q;

endmodule
